// ===== hw/rtl/popl_pkg.sv =====
// Shared constants, types and widths for the point-to-line projection pipeline.
package popl_pkg;

    // Number of coordinate ports, and how many of them take part in the math.
    localparam int MAXD = 4;
    localparam int DIMS = 4;

    // Coordinate and intermediate widths (raw Q16.16 units).
    localparam int CW    = 32;            // coordinate
    localparam int DW    = CW + 1;        // difference of two coordinates
    localparam int PW    = 2 * DW;        // product of two differences
    localparam int NUMW  = PW + 1;        // signed dot product P-A with B-A
    localparam int MAGW  = PW;            // magnitude of the dot product, and the denominator
    localparam int QW    = CW;            // quotient bits, one per divider stage
    localparam int LOW_W = MAGW / 2;      // low slice of the magnitude for the split multiply
    localparam int HIGH_W = MAGW - LOW_W; // high slice
    localparam int PPW   = LOW_W + CW;    // partial product width
    localparam int PRODW = MAGW + CW;     // full dividend width
    localparam int SUMW  = CW + 3;        // A plus or minus the rounded quotient

    // Latency of the front end (differences, products, sums, magnitude) and of a lane.
    localparam int FRONT_LAT = 4;
    localparam int LANE_LAT  = QW + 4;
    localparam int TOTAL_LAT = FRONT_LAT + LANE_LAT;

    // Configuration register map.
    localparam int CFG_IDX_W  = $clog2(2 * MAXD);
    localparam int SEL_W      = $clog2(MAXD);
    localparam int START_BASE = 0;
    localparam int END_BASE   = MAXD;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [DW-1:0] diff_t;
    typedef logic [CW-1:0]        dmag_t;
    typedef logic [MAGW-1:0]      mag_t;
    typedef logic signed [NUMW-1:0] num_t;

    // Control that travels alongside each request in the pipeline.
    typedef struct packed {
        logic valid;
        logic last;
        logic degen;
    } meta_t;

endpackage

// ===== hw/rtl/project_point_onto_line.sv =====
// Top level: configuration registers, pipeline control and the coordinate lanes.
//
// Projects each point P onto the line through the configured points A and B,
// all coordinates signed Q16.16. A request on the s_ channel carries one point
// and a last marker; the m_ channel returns one request per point with the
// projected coordinates (rounded to nearest, saturated), a degenerate flag that
// is set when A equals B (the result is then A), and the copied last marker.
// Line points are written through cfg_wen/cfg_index/cfg_wdata: indexes 0 to 3
// are A, 4 to 7 are B. Write them only while no request is in flight.
// The pipeline has four front-end stages (differences, products, sums,
// magnitude), a two-stage split multiply, one divider stage per quotient bit
// (32), one rounding stage and the output register.
// Throughput is one point per cycle. When the receiver holds m_ready low with
// a result waiting, the whole pipeline freezes and s_ready drops; nothing is
// lost or repeated, and bubbles keep their place.
// Reset clears A, B and all valid bits; no request is presented after reset
// until a new point is accepted.
module project_point_onto_line (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wen,
    input  logic [popl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [popl_pkg::CW-1:0]         cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  popl_pkg::coord_t                s_coord_0,
    input  popl_pkg::coord_t                s_coord_1,
    input  popl_pkg::coord_t                s_coord_2,
    input  popl_pkg::coord_t                s_coord_3,
    input  logic                            s_last_point,
    output logic                            m_valid,
    input  logic                            m_ready,
    output popl_pkg::coord_t                m_proj_0,
    output popl_pkg::coord_t                m_proj_1,
    output popl_pkg::coord_t                m_proj_2,
    output popl_pkg::coord_t                m_proj_3,
    output logic                            m_degenerate,
    output logic                            m_last_out
);
    import popl_pkg::*;

    coord_t start_reg [MAXD];
    coord_t end_reg   [MAXD];
    meta_t  meta_reg  [TOTAL_LAT];
    meta_t  meta_next [TOTAL_LAT];

    coord_t p_w    [MAXD];
    coord_t proj_w [MAXD];
    num_t   num3;
    mag_t   den3;
    dmag_t  dmag3  [MAXD];
    logic   dneg3  [MAXD];
    coord_t a3     [MAXD];

    mag_t   nmag4_reg;
    logic   nneg4_reg;
    mag_t   den4_reg;
    dmag_t  dmag4_reg [MAXD];
    logic   dneg4_reg [MAXD];
    coord_t a4_reg    [MAXD];
    num_t   num_neg;
    logic   en;

    // The pipeline moves whenever the output register is free or being taken.
    assign en      = !meta_reg[TOTAL_LAT-1].valid || m_ready;
    assign s_ready = en;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MAXD; k++) begin
                start_reg[k] <= '0;
                end_reg[k]   <= '0;
            end
        end else if (cfg_wen) begin
            if (int'(cfg_index) < END_BASE) begin
                start_reg[cfg_index[SEL_W-1:0]] <= cfg_wdata;
            end else if (int'(cfg_index) < END_BASE + MAXD) begin
                end_reg[cfg_index[SEL_W-1:0]] <= cfg_wdata;
            end
        end
    end

    assign p_w[0] = s_coord_0;
    assign p_w[1] = s_coord_1;
    assign p_w[2] = s_coord_2;
    assign p_w[3] = s_coord_3;

    popl_dot u_dot (
        .aclk   (aclk),
        .en     (en),
        .p_i    (p_w),
        .a_i    (start_reg),
        .b_i    (end_reg),
        .num_o  (num3),
        .den_o  (den3),
        .dmag_o (dmag3),
        .dneg_o (dneg3),
        .a_o    (a3)
    );

    // Magnitude and sign of the numerator.
    assign num_neg = -num3;

    always_ff @(posedge aclk) begin
        if (en) begin
            nmag4_reg <= num3[NUMW-1] ? num_neg[MAGW-1:0] : num3[MAGW-1:0];
            nneg4_reg <= num3[NUMW-1];
            den4_reg  <= den3;
            for (int k = 0; k < MAXD; k++) begin
                dmag4_reg[k] <= dmag3[k];
                dneg4_reg[k] <= dneg3[k];
                a4_reg[k]    <= a3[k];
            end
        end
    end

    // Control that runs beside the data; the degenerate flag joins at the magnitude stage.
    always_comb begin
        meta_next[0] = '{valid: s_valid, last: s_last_point, degen: 1'b0};
        for (int i = 1; i < TOTAL_LAT; i++) begin
            meta_next[i] = meta_reg[i-1];
        end
        meta_next[FRONT_LAT-1].degen = (den3 == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TOTAL_LAT; i++) begin
                meta_reg[i] <= '0;
            end
        end else if (en) begin
            for (int i = 0; i < TOTAL_LAT; i++) begin
                meta_reg[i] <= meta_next[i];
            end
        end
    end

    // One lane per used coordinate; unused coordinates read zero.
    for (genvar k = 0; k < MAXD; k++) begin : g_lane
        if (k < DIMS) begin : g_used
            popl_lane u_lane (
                .aclk    (aclk),
                .en      (en),
                .nmag_i  (nmag4_reg),
                .nneg_i  (nneg4_reg),
                .den_i   (den4_reg),
                .dmag_i  (dmag4_reg[k]),
                .dneg_i  (dneg4_reg[k]),
                .a_i     (a4_reg[k]),
                .degen_i (meta_reg[FRONT_LAT-1].degen),
                .proj_o  (proj_w[k])
            );
        end else begin : g_unused
            assign proj_w[k] = '0;
        end
    end

    assign m_valid      = meta_reg[TOTAL_LAT-1].valid;
    assign m_degenerate = meta_reg[TOTAL_LAT-1].degen;
    assign m_last_out   = meta_reg[TOTAL_LAT-1].last;
    assign m_proj_0     = proj_w[0];
    assign m_proj_1     = proj_w[1];
    assign m_proj_2     = proj_w[2];
    assign m_proj_3     = proj_w[3];

    // An empty output register never blocks new requests.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low while the output register is empty");

    // Reset empties the pipeline.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result presented right after reset");

    // When the pipeline advances, the output takes the stage before it.
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && en) |=> (m_valid == $past(meta_reg[TOTAL_LAT-2].valid)))
        else $error("request lost or repeated at the output stage");

    // A stalled output keeps its flags.
    a_stall_holds_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(m_degenerate) && $stable(m_last_out)))
        else $error("output flags changed during a stall");

endmodule

// ===== hw/rtl/popl_dot.sv =====
// Front end: coordinate differences, products and the two dot products.
module popl_dot (
    input  logic                  aclk,
    input  logic                  en,
    input  popl_pkg::coord_t      p_i    [popl_pkg::MAXD],
    input  popl_pkg::coord_t      a_i    [popl_pkg::MAXD],
    input  popl_pkg::coord_t      b_i    [popl_pkg::MAXD],
    output popl_pkg::num_t        num_o,
    output popl_pkg::mag_t        den_o,
    output popl_pkg::dmag_t       dmag_o [popl_pkg::MAXD],
    output logic                  dneg_o [popl_pkg::MAXD],
    output popl_pkg::coord_t      a_o    [popl_pkg::MAXD]
);
    import popl_pkg::*;

    diff_t                  e1_reg  [MAXD];
    diff_t                  d1_reg  [MAXD];
    coord_t                 a1_reg  [MAXD];
    logic signed [PW-1:0]   pe2_reg [MAXD];
    logic [2*CW-1:0]        sq2_reg [MAXD];
    dmag_t                  dmag2_reg [MAXD];
    logic                   dneg2_reg [MAXD];
    coord_t                 a2_reg  [MAXD];
    num_t                   num3_reg;
    mag_t                   den3_reg;
    dmag_t                  dmag3_reg [MAXD];
    logic                   dneg3_reg [MAXD];
    coord_t                 a3_reg  [MAXD];

    diff_t                  e1_next [MAXD];
    diff_t                  d1_next [MAXD];
    logic signed [PW-1:0]   pe2_next [MAXD];
    logic signed [PW-1:0]   sq_full [MAXD];
    diff_t                  dabs [MAXD];
    num_t                   num3_next;
    mag_t                   den3_next;

    // Stage one: differences from point A.
    always_comb begin
        for (int k = 0; k < MAXD; k++) begin
            e1_next[k] = DW'(p_i[k]) - DW'(a_i[k]);
            d1_next[k] = DW'(b_i[k]) - DW'(a_i[k]);
        end
    end

    // Stage two: per-coordinate products and direction magnitudes.
    always_comb begin
        for (int k = 0; k < MAXD; k++) begin
            pe2_next[k] = PW'(e1_reg[k]) * PW'(d1_reg[k]);
            sq_full[k]  = PW'(d1_reg[k]) * PW'(d1_reg[k]);
            dabs[k]     = d1_reg[k][DW-1] ? -d1_reg[k] : d1_reg[k];
        end
    end

    // Stage three: sum the products over the used coordinates.
    always_comb begin
        num3_next = '0;
        den3_next = '0;
        for (int k = 0; k < DIMS; k++) begin
            num3_next = num3_next + NUMW'(pe2_reg[k]);
            den3_next = den3_next + MAGW'(sq2_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < MAXD; k++) begin
                e1_reg[k]    <= e1_next[k];
                d1_reg[k]    <= d1_next[k];
                a1_reg[k]    <= a_i[k];
                pe2_reg[k]   <= pe2_next[k];
                sq2_reg[k]   <= sq_full[k][2*CW-1:0];
                dmag2_reg[k] <= dabs[k][CW-1:0];
                dneg2_reg[k] <= d1_reg[k][DW-1];
                a2_reg[k]    <= a1_reg[k];
                dmag3_reg[k] <= dmag2_reg[k];
                dneg3_reg[k] <= dneg2_reg[k];
                a3_reg[k]    <= a2_reg[k];
            end
            num3_reg <= num3_next;
            den3_reg <= den3_next;
        end
    end

    assign num_o = num3_reg;
    assign den_o = den3_reg;
    always_comb begin
        for (int k = 0; k < MAXD; k++) begin
            dmag_o[k] = dmag3_reg[k];
            dneg_o[k] = dneg3_reg[k];
            a_o[k]    = a3_reg[k];
        end
    end

endmodule

// ===== hw/rtl/popl_lane.sv =====
// One output coordinate: split multiply, one-bit-per-stage divider, rounding and saturation.
module popl_lane (
    input  logic              aclk,
    input  logic              en,
    input  popl_pkg::mag_t    nmag_i,
    input  logic              nneg_i,
    input  popl_pkg::mag_t    den_i,
    input  popl_pkg::dmag_t   dmag_i,
    input  logic              dneg_i,
    input  popl_pkg::coord_t  a_i,
    input  logic              degen_i,
    output popl_pkg::coord_t  proj_o
);
    import popl_pkg::*;

    localparam coord_t SAT_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam coord_t SAT_MIN = {1'b1, {(CW-1){1'b0}}};

    // Multiply stage.
    logic [PPW-1:0]   pl_reg;
    logic [PPW-1:0]   ph_reg;
    mag_t             den1_reg;
    coord_t           a1_reg;
    logic             neg1_reg;
    logic             deg1_reg;

    // Divider stages, index 0 is the initial remainder.
    mag_t             r_reg   [QW+1];
    logic [QW-1:0]    low_reg [QW+1];
    logic [QW-1:0]    q_reg   [QW+1];
    mag_t             den_reg [QW+1];
    coord_t           a_reg   [QW+1];
    logic             neg_reg [QW+1];
    logic             deg_reg [QW+1];
    logic             ovf_reg [QW+1];

    // Rounding stage and final result.
    logic [QW:0]      qr_reg;
    coord_t           ar_reg;
    logic             negr_reg;
    logic             degr_reg;
    logic             ovfr_reg;
    coord_t           res_reg;

    logic [PRODW-1:0] prod;
    logic [MAGW:0]    t_w   [QW];
    logic [MAGW:0]    sub_w [QW];
    logic             ge_w  [QW];
    logic             rnd;
    logic signed [SUMW-1:0] sa;
    logic signed [SUMW-1:0] qx;
    logic signed [SUMW-1:0] sum;
    logic [SUMW-CW:0] top_bits;
    coord_t           res_next;

    // Dividend assembled from the two partial products.
    assign prod = PRODW'(pl_reg) + (PRODW'(ph_reg) << LOW_W);

    // Restoring division: each stage brings down one dividend bit.
    always_comb begin
        for (int j = 0; j < QW; j++) begin
            t_w[j]   = {r_reg[j], low_reg[j][QW-1]};
            sub_w[j] = t_w[j] - {1'b0, den_reg[j]};
            ge_w[j]  = t_w[j] >= {1'b0, den_reg[j]};
        end
    end

    // Round half away from zero on the remainder, then apply sign and saturate.
    assign rnd      = {r_reg[QW], 1'b0} >= {1'b0, den_reg[QW]};
    assign sa       = SUMW'(ar_reg);
    assign qx       = $signed(SUMW'(qr_reg));
    assign sum      = negr_reg ? (sa - qx) : (sa + qx);
    assign top_bits = sum[SUMW-1:CW-1];

    // A quotient too wide for the divider always lands outside the coordinate range.
    always_comb begin
        if (degr_reg) begin
            res_next = ar_reg;
        end else if (ovfr_reg) begin
            res_next = negr_reg ? SAT_MIN : SAT_MAX;
        end else if ((&top_bits) || !(|top_bits)) begin
            res_next = sum[CW-1:0];
        end else if (sum[SUMW-1]) begin
            res_next = SAT_MIN;
        end else begin
            res_next = SAT_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pl_reg   <= PPW'(nmag_i[LOW_W-1:0]) * PPW'(dmag_i);
            ph_reg   <= PPW'(nmag_i[MAGW-1:LOW_W]) * PPW'(dmag_i);
            den1_reg <= den_i;
            a1_reg   <= a_i;
            neg1_reg <= nneg_i ^ dneg_i;
            deg1_reg <= degen_i;

            r_reg[0]   <= prod[PRODW-1:QW];
            low_reg[0] <= prod[QW-1:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den1_reg;
            a_reg[0]   <= a1_reg;
            neg_reg[0] <= neg1_reg;
            deg_reg[0] <= deg1_reg;
            ovf_reg[0] <= prod[PRODW-1:QW] >= den1_reg;

            for (int j = 0; j < QW; j++) begin
                r_reg[j+1]   <= ge_w[j] ? sub_w[j][MAGW-1:0] : t_w[j][MAGW-1:0];
                low_reg[j+1] <= {low_reg[j][QW-2:0], 1'b0};
                q_reg[j+1]   <= {q_reg[j][QW-2:0], ge_w[j]};
                den_reg[j+1] <= den_reg[j];
                a_reg[j+1]   <= a_reg[j];
                neg_reg[j+1] <= neg_reg[j];
                deg_reg[j+1] <= deg_reg[j];
                ovf_reg[j+1] <= ovf_reg[j];
            end

            qr_reg   <= (QW+1)'(q_reg[QW]) + (QW+1)'(rnd);
            ar_reg   <= a_reg[QW];
            negr_reg <= neg_reg[QW];
            degr_reg <= deg_reg[QW];
            ovfr_reg <= ovf_reg[QW];
            res_reg  <= res_next;
        end
    end

    assign proj_o = res_reg;

endmodule

// ===== tb/sv/project_point_onto_line_checker.sv =====
// Checker for the point-to-line projection block: predicts results and compares them.
module project_point_onto_line_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wen,
    input  logic [popl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [popl_pkg::CW-1:0]           cfg_wdata,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  popl_pkg::coord_t                  s_coord_0,
    input  popl_pkg::coord_t                  s_coord_1,
    input  popl_pkg::coord_t                  s_coord_2,
    input  popl_pkg::coord_t                  s_coord_3,
    input  logic                              s_last_point,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  popl_pkg::coord_t                  m_proj_0,
    input  popl_pkg::coord_t                  m_proj_1,
    input  popl_pkg::coord_t                  m_proj_2,
    input  popl_pkg::coord_t                  m_proj_3,
    input  logic                              m_degenerate,
    input  logic                              m_last_out,
    output int                                error_count,
    output int                                pending_count,
    output int                                result_count,
    output int                                degenerate_count,
    output int                                saturated_count
);
    import popl_pkg::*;

    typedef struct {
        coord_t proj [MAXD];
        logic   degen;
        logic   last;
    } projection_t;

    coord_t      line_start [MAXD];
    coord_t      line_end [MAXD];
    projection_t expected_projections [$];

    // Exact projection with half-away-from-zero rounding and saturation.
    function automatic projection_t project_point(coord_t pt [MAXD], logic last);
        projection_t        r;
        logic signed [39:0]  d [MAXD];
        logic signed [39:0]  e;
        logic signed [127:0] num;
        logic signed [127:0] den;
        logic signed [127:0] prod;
        logic signed [127:0] mag;
        logic signed [127:0] q;
        logic signed [127:0] rem;
        logic signed [127:0] res;
        num = 0;
        den = 0;
        for (int k = 0; k < MAXD; k++) begin
            r.proj[k] = '0;
            d[k] = 0;
        end
        for (int k = 0; k < DIMS; k++) begin
            d[k] = 40'(line_end[k]) - 40'(line_start[k]);
            e = 40'(pt[k]) - 40'(line_start[k]);
            num += 128'(e) * 128'(d[k]);
            den += 128'(d[k]) * 128'(d[k]);
        end
        r.degen = (den == 0);
        r.last = last;
        for (int k = 0; k < DIMS; k++) begin
            res = 128'(line_start[k]);
            if (!r.degen) begin
                prod = num * 128'(d[k]);
                mag = prod < 0 ? -prod : prod;
                q = mag / den;
                rem = mag - q * den;
                if (2 * rem >= den) q += 1;
                res = prod < 0 ? res - q : res + q;
            end
            if (res > 128'sd2147483647) res = 128'sd2147483647;
            if (res < -128'sd2147483648) res = -128'sd2147483648;
            r.proj[k] = res[31:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on result %0d: %s got %h expected %h", result_count, what, got, want);
        error_count++;
    endtask

    assign pending_count = expected_projections.size();

    // Track configuration, predict on accepted points, compare on accepted results.
    always @(posedge aclk) begin
        coord_t      pt [MAXD];
        projection_t want;
        coord_t      got [MAXD];
        if (!aresetn) begin
            for (int k = 0; k < MAXD; k++) begin
                line_start[k] <= '0;
                line_end[k] <= '0;
            end
            expected_projections.delete();
            error_count = 0;
            result_count = 0;
            degenerate_count = 0;
            saturated_count = 0;
        end else begin
            if (cfg_wen) begin
                if (cfg_index < END_BASE) line_start[cfg_index[SEL_W-1:0]] <= cfg_wdata;
                else line_end[cfg_index[SEL_W-1:0]] <= cfg_wdata;
            end
            if (s_valid && s_ready) begin
                pt[0] = s_coord_0;
                pt[1] = s_coord_1;
                pt[2] = s_coord_2;
                pt[3] = s_coord_3;
                expected_projections.push_back(project_point(pt, s_last_point));
            end
            if (m_valid && m_ready) begin
                if (expected_projections.size() == 0) begin
                    $display("unexpected result %0d with nothing pending", result_count);
                    error_count++;
                end else begin
                    want = expected_projections.pop_front();
                    got[0] = m_proj_0;
                    got[1] = m_proj_1;
                    got[2] = m_proj_2;
                    got[3] = m_proj_3;
                    for (int k = 0; k < MAXD; k++) begin
                        if (got[k] !== want.proj[k])
                            report_mismatch($sformatf("proj_%0d", k), got[k], want.proj[k]);
                        if (want.proj[k] == 32'h7FFFFFFF || want.proj[k] == 32'h80000000)
                            saturated_count++;
                    end
                    if (m_degenerate !== want.degen)
                        report_mismatch("degenerate", 32'(m_degenerate), 32'(want.degen));
                    if (m_last_out !== want.last)
                        report_mismatch("last_out", 32'(m_last_out), 32'(want.last));
                    if (want.degen) degenerate_count++;
                end
                result_count++;
            end
        end
    end

endmodule

// ===== tb/sv/project_point_onto_line_test.sv =====
// Testbench top: clock, reset, configuration phases, point stimulus and the verdict.
module project_point_onto_line_test;
    import popl_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CW-1:0]        cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    coord_t               s_coord_0 = '0;
    coord_t               s_coord_1 = '0;
    coord_t               s_coord_2 = '0;
    coord_t               s_coord_3 = '0;
    logic                 s_last_point = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    coord_t               m_proj_0;
    coord_t               m_proj_1;
    coord_t               m_proj_2;
    coord_t               m_proj_3;
    logic                 m_degenerate;
    logic                 m_last_out;
    int                   error_count;
    int                   pending_count;
    int                   result_count;
    int                   degenerate_count;
    int                   saturated_count;

    int  sender_idle_pct = 0;
    int  receiver_stall_pct = 0;
    bit  hold_receiver = 1'b0;
    int  idle_cycles = 0;
    int  points_sent = 0;

    always #2 aclk = ~aclk;

    project_point_onto_line uut (.*);

    project_point_onto_line_checker checker_i (.*);

    // Receiver: random stalls, or a long hold-off while hold_receiver is set.
    always @(posedge aclk) begin
        if (hold_receiver) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Watchdog: counts cycles without any accepted request, configuration write, reset or receiver hold-off.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wen || !aresetn
            || hold_receiver)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results pending", pending_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(9))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 600) - 300;
            3, 4: return $urandom;
            default: return {{12{1'b0}}, 20'($urandom)} - 32'h00080000;
        endcase
    endfunction

    // One register write; the caller drops the write enable after the last one.
    task automatic write_reg(int idx, logic [31:0] value);
        cfg_wen <= 1'b1;
        cfg_index <= CFG_IDX_W'(idx);
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    // Stop offering points and wait for the pipeline to drain.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (TOTAL_LAT + 4) @(posedge aclk);
    endtask

    task automatic set_line(logic [31:0] a [MAXD], logic [31:0] b [MAXD]);
        drain();
        for (int k = 0; k < MAXD; k++) write_reg(START_BASE + k, a[k]);
        for (int k = 0; k < MAXD; k++) write_reg(END_BASE + k, b[k]);
        cfg_wen <= 1'b0;
    endtask

    // Offer one point; valid stays high until the request is accepted.
    task automatic send_point(logic [31:0] c0, c1, c2, c3, logic last);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_coord_0 <= c0;
        s_coord_1 <= c1;
        s_coord_2 <= c2;
        s_coord_3 <= c3;
        s_last_point <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        points_sent++;
    endtask

    task automatic send_random(int count);
        for (int i = 0; i < count; i++)
            send_point(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                       1'($urandom_range(1)));
    endtask

    task automatic random_line();
        logic [31:0] a [MAXD];
        logic [31:0] b [MAXD];
        for (int k = 0; k < MAXD; k++) begin
            a[k] = pick_coord();
            b[k] = ($urandom_range(7) == 0) ? a[k] : pick_coord();
        end
        set_line(a, b);
    endtask

    initial begin
        logic [31:0] a [MAXD];
        logic [31:0] b [MAXD];
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Registers at reset: A equals B, so every point is degenerate.
        send_point(32'h00010000, 32'hFFFF0000, 32'h7FFFFFFF, 32'h80000000, 1'b1);

        // Diagonal line through the origin, with extreme and rounding points.
        a = '{0, 0, 0, 0};
        b = '{32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000};
        set_line(a, b);
        send_point(32'h00030000, 32'h00010000, 0, 0, 1'b0);
        send_point(1, 0, 0, 0, 1'b0);
        send_point(2, 0, 0, 0, 1'b0);
        send_point(-2, 0, 0, 0, 1'b0);
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
        send_point(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1'b1);

        // Extreme endpoints, driving the result past the range.
        a = '{32'h80000000, 32'h80000000, 32'h7FFFFFFF, 0};
        b = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1};
        set_line(a, b);
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b0);
        send_point(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1'b0);
        send_point(0, 0, 0, 0, 1'b0);
        send_point(32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA, 32'h12345678, 1'b1);

        // Short direction with a far point: the quotient outgrows 32 bits.
        a = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000};
        b = '{32'h80000002, 32'h80000001, 32'h80000001, 32'h80000001};
        set_line(a, b);
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
        send_point(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000, 1'b1);

        // Line along a single axis, and a degenerate line away from the origin.
        a = '{32'h7FFFFFFF, 32'h80000000, 5, 32'h80000000};
        b = '{32'h7FFFFFFF, 32'h80000000, 7, 32'h80000000};
        set_line(a, b);
        send_point(32'h80000000, 32'h7FFFFFFF, 6, 32'h7FFFFFFF, 1'b0);
        send_point(0, 0, 32'h7FFFFFFF, 0, 1'b1);
        b[2] = 5;
        set_line(a, b);
        send_point(32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 32'hF0F0F0F0, 1'b1);

        // Random phases: no idling, sender idle, receiver stalling, both.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 77; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 77; end
                default: begin sender_idle_pct = 16; receiver_stall_pct = 16; end
            endcase
            random_line();
            if (phase == 4) begin
                // Long receiver hold-off while points keep coming.
                sender_idle_pct = 0;
                fork
                    begin
                        hold_receiver = 1'b1;
                        repeat (300) @(posedge aclk);
                        hold_receiver = 1'b0;
                    end
                    send_random(85);
                join
            end else begin
                send_random(85);
            end
        end

        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        drain();
        $display("Sent %0d points over the reset line and thirteen written lines; %0d results checked,",
                 points_sent, result_count);
        $display("%0d degenerate, %0d saturated coordinates.",
                 degenerate_count, saturated_count);
        if (error_count == 0 && pending_count == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule
